### design/cbeq_pkg.sv
// shared types, constants and codes for the cascaded biquad equaliser
package cbeq_pkg;

  localparam int SAMPLE_BITS        = 24;
  localparam int BAND_VAL_BITS      = 32;
  localparam int COEF_BITS          = 32;
  localparam int CFG_BITS           = 4;
  localparam int CHAN_BITS          = 3;
  localparam int BAND_IDX_BITS      = 4;
  localparam int COEF_IDX_BITS      = 3;
  localparam int COEFS_PER_BAND     = 5;
  localparam int DEF_BAND_COUNT     = 10;
  localparam int DEF_MAX_CHANNELS   = 8;
  localparam int DEF_COEF_FRAC_BITS = 28;

  localparam logic [CFG_BITS-1:0] CH_COUNT_RESET = 4'd2;

  typedef enum logic [1:0] {
    OP_PROCESS = 2'd0,
    OP_LOAD    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_B0 = 3'd0,
    K_B1 = 3'd1,
    K_B2 = 3'd2,
    K_A1 = 3'd3,
    K_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                              op;
    logic signed [SAMPLE_BITS-1:0]    audio_in;
    logic [BAND_IDX_BITS-1:0]         band;
    logic [COEF_IDX_BITS-1:0]         coef_index;
    logic signed [COEF_BITS-1:0]      coef_value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]    sample_out;
    logic [CHAN_BITS-1:0]             channel;
  } out_word_t;

  typedef struct packed {
    logic      start;
    logic      load_coef;
    logic      clear;
    logic      rd;
    logic      mac;
    coef_sel_t k;
    logic      fin;
    logic      last;
    logic      out_load;
    logic      out_src_fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### design/cbeq_ctrl.sv
// sequencer for the band loop and the five-tap multiply-accumulate
module cbeq_ctrl #(
  parameter int BAND_COUNT = cbeq_pkg::DEF_BAND_COUNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cbeq_pkg::op_t     in_op,
  input  cbeq_pkg::status_t status,
  output logic              in_ready,
  output cbeq_pkg::cmd_t    cmd
);
  import cbeq_pkg::*;

  localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  state_t            state_r, state_nxt;
  coef_sel_t         k_r, k_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic              last_band;

  assign last_band = (band_r == BAND_W'(BAND_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= K_B0;
      band_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      band_r  <= band_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    band_nxt  = band_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.k     = k_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_PROCESS: begin
              cmd.start = 1'b1;
              band_nxt  = '0;
              state_nxt = ST_READ;
            end
            OP_LOAD:  cmd.load_coef = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        k_nxt     = K_B0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (k_r == K_A2) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt = coef_sel_t'(k_r + 3'd1);
        end
      end
      ST_FIN: begin
        cmd.fin  = 1'b1;
        cmd.last = last_band;
        if (!last_band) begin
          cmd.rd    = 1'b1;
          band_nxt  = band_r + 1'b1;
          k_nxt     = K_B0;
          state_nxt = ST_MAC;
        end else if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_src_fin = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_mac_ends_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && k_r == K_A2) |=> state_r == ST_FIN)
    else $error("mac run did not end in finish");

  a_next_band_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !last_band) |=> (state_r == ST_MAC && k_r == K_B0))
    else $error("next band did not restart at b0");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register full");

endmodule

### design/cbeq_datapath.sv
// coefficient and history stores, shared multiplier, accumulator and output register
module cbeq_datapath #(
  parameter int BAND_COUNT     = cbeq_pkg::DEF_BAND_COUNT,
  parameter int MAX_CHANNELS   = cbeq_pkg::DEF_MAX_CHANNELS,
  parameter int COEF_FRAC_BITS = cbeq_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbeq_pkg::in_word_t            in_word,
  input  logic                          cfg_valid,
  input  logic [cbeq_pkg::CFG_BITS-1:0] cfg_data,
  input  cbeq_pkg::cmd_t                cmd,
  output cbeq_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cbeq_pkg::out_word_t           out_word
);
  import cbeq_pkg::*;

  localparam int COEF_DEPTH = BAND_COUNT * COEFS_PER_BAND;
  localparam int HIST_DEPTH = BAND_COUNT * MAX_CHANNELS;
  localparam int CA_W   = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int HA_W   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = CFG_BITS + 1;
  localparam int PROD_W = COEF_BITS + BAND_VAL_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int LD_W   = BAND_IDX_BITS + 4;
  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  // configuration and channel rotation
  logic [CFG_BITS-1:0] cc_r;
  logic [CH_W-1:0]     pos_r, ch_r, ch_sel, pos_nxt;
  logic [CNT_W-1:0]    cc_ext, cnt_eff, ch_inc;

  // band value and address bases
  logic signed [BAND_VAL_BITS-1:0] x_r;
  logic [HA_W-1:0]                 hist_base_r;
  logic [CA_W-1:0]                 coef_base_r;

  // stores
  logic signed [COEF_BITS-1:0]     coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]           coef_vld_r;
  logic signed [BAND_VAL_BITS-1:0] x1_mem [HIST_DEPTH];
  logic signed [BAND_VAL_BITS-1:0] x2_mem [HIST_DEPTH];
  logic signed [BAND_VAL_BITS-1:0] y1_mem [HIST_DEPTH];
  logic signed [BAND_VAL_BITS-1:0] y2_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]           hist_vld_r;

  logic signed [COEF_BITS-1:0]     coef_rd_r;
  logic                            coef_rv_r;
  logic signed [BAND_VAL_BITS-1:0] hx1_rd_r, hx2_rd_r, hy1_rd_r, hy2_rd_r;
  logic                            hist_rv_r;

  // arithmetic
  logic signed [PROD_W-1:0]        prod_r, prod_c;
  logic                            prod_neg_r;
  logic signed [ACC_W-1:0]         acc_r, acc_add, prod_ext, shifted;
  logic signed [COEF_BITS-1:0]     coef_op;
  logic signed [BAND_VAL_BITS-1:0] data_op, hx1_op, hx2_op, hy1_op, hy2_op;
  logic signed [BAND_VAL_BITS-1:0] band_y, out_src;
  logic                            band_fits, out_fits;
  logic signed [SAMPLE_BITS-1:0]   out_sat;

  // addressing
  logic [LD_W-1:0] ld_full;
  logic            ld_ok;
  logic [CA_W:0]   coef_rd_full;
  logic            coef_rd_en;
  logic [HA_W:0]   hist_rd_full;

  // output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CHAN_BITS-1:0]          out_chan_r;

  // effective channel count and channel of the next sample
  always_comb begin
    cc_ext = {1'b0, cc_r};
    if (cc_ext == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cc_ext > CNT_W'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cc_ext;
    end
    ch_sel  = (CNT_W'(pos_r) >= cnt_eff) ? '0 : pos_r;
    ch_inc  = CNT_W'(ch_sel) + 1'b1;
    pos_nxt = (ch_inc >= cnt_eff) ? '0 : CH_W'(ch_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= CH_COUNT_RESET;
      pos_r <= '0;
    end else begin
      if (cfg_valid) cc_r <= cfg_data;
      if (cmd.clear) begin
        pos_r <= '0;
      end else if (cmd.start) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // address generation
  always_comb begin
    ld_full = LD_W'({in_word.band, 2'b00}) + LD_W'(in_word.band) + LD_W'(in_word.coef_index);
    ld_ok   = (in_word.band < BAND_COUNT) && (in_word.coef_index < COEFS_PER_BAND);
    if (cmd.fin) begin
      coef_rd_full = {1'b0, coef_base_r} + (CA_W+1)'(COEFS_PER_BAND);
    end else if (cmd.mac) begin
      coef_rd_full = {1'b0, coef_base_r} + (CA_W+1)'(cmd.k) + 1'b1;
    end else begin
      coef_rd_full = {1'b0, coef_base_r};
    end
    coef_rd_en   = cmd.rd || (cmd.mac && cmd.k != K_A2);
    hist_rd_full = {1'b0, hist_base_r} + (cmd.fin ? (HA_W+1)'(MAX_CHANNELS) : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ch_r        <= ch_sel;
      x_r         <= BAND_VAL_BITS'(in_word.audio_in);
      hist_base_r <= HA_W'(ch_sel);
      coef_base_r <= '0;
    end else if (cmd.fin) begin
      x_r <= band_y;
      if (!cmd.last) begin
        hist_base_r <= hist_rd_full[HA_W-1:0];
        coef_base_r <= coef_rd_full[CA_W-1:0];
      end
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.load_coef && ld_ok) coef_mem[ld_full[CA_W-1:0]] <= in_word.coef_value;
    if (coef_rd_en) begin
      coef_rd_r <= coef_mem[coef_rd_full[CA_W-1:0]];
      coef_rv_r <= coef_vld_r[coef_rd_full[CA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (cmd.load_coef && ld_ok) begin
      coef_vld_r[ld_full[CA_W-1:0]] <= 1'b1;
    end
  end

  // history stores, all four share one address and one valid bit
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      x1_mem[hist_base_r] <= x_r;
      x2_mem[hist_base_r] <= hx1_op;
      y1_mem[hist_base_r] <= band_y;
      y2_mem[hist_base_r] <= hy1_op;
    end
    if (cmd.rd) begin
      hx1_rd_r  <= x1_mem[hist_rd_full[HA_W-1:0]];
      hx2_rd_r  <= x2_mem[hist_rd_full[HA_W-1:0]];
      hy1_rd_r  <= y1_mem[hist_rd_full[HA_W-1:0]];
      hy2_rd_r  <= y2_mem[hist_rd_full[HA_W-1:0]];
      hist_rv_r <= hist_vld_r[hist_rd_full[HA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (cmd.clear) begin
      hist_vld_r <= '0;
    end else if (cmd.fin) begin
      hist_vld_r[hist_base_r] <= 1'b1;
    end
  end

  // operand selection, never-written entries read as zero
  always_comb begin
    coef_op = coef_rv_r ? coef_rd_r : '0;
    hx1_op  = hist_rv_r ? hx1_rd_r : '0;
    hx2_op  = hist_rv_r ? hx2_rd_r : '0;
    hy1_op  = hist_rv_r ? hy1_rd_r : '0;
    hy2_op  = hist_rv_r ? hy2_rd_r : '0;
    case (cmd.k)
      K_B0:    data_op = x_r;
      K_B1:    data_op = hx1_op;
      K_B2:    data_op = hx2_op;
      K_A1:    data_op = hy1_op;
      K_A2:    data_op = hy2_op;
      default: data_op = '0;
    endcase
    prod_c = coef_op * data_op;
  end

  // accumulate exactly, rounding offset preloaded, feedback terms subtracted
  always_comb begin
    prod_ext  = ACC_W'(prod_r);
    acc_add   = prod_neg_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    shifted   = acc_add >>> COEF_FRAC_BITS;
    band_fits = (&shifted[ACC_W-1:BAND_VAL_BITS-1]) || !(|shifted[ACC_W-1:BAND_VAL_BITS-1]);
    band_y    = band_fits ? shifted[BAND_VAL_BITS-1:0]
                          : {shifted[ACC_W-1], {(BAND_VAL_BITS-1){~shifted[ACC_W-1]}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      prod_r     <= prod_c;
      prod_neg_r <= (cmd.k == K_A1) || (cmd.k == K_A2);
      acc_r      <= (cmd.k == K_B0) ? ACC_HALF : acc_add;
    end
  end

  // output saturation and register
  always_comb begin
    out_src  = cmd.out_src_fin ? band_y : x_r;
    out_fits = (&out_src[BAND_VAL_BITS-1:SAMPLE_BITS-1]) ||
               !(|out_src[BAND_VAL_BITS-1:SAMPLE_BITS-1]);
    out_sat  = out_fits ? out_src[SAMPLE_BITS-1:0]
                        : {out_src[BAND_VAL_BITS-1], {(SAMPLE_BITS-1){~out_src[BAND_VAL_BITS-1]}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= out_sat;
      out_chan_r   <= CHAN_BITS'(ch_r);
    end
  end

  assign status.out_free     = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_word.sample_out = out_sample_r;
  assign out_word.channel    = out_chan_r;

  a_start_sets_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (hist_base_r == HA_W'(ch_r) && coef_base_r == '0))
    else $error("band bases not set from channel at start");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (hist_vld_r == '0 && pos_r == '0))
    else $error("clear left history or channel position");

endmodule

### design/cascaded_biquad_equalizer_core.sv
// top level of the cascaded biquad equaliser: controller plus datapath
//
// Multichannel interleaved audio equaliser built from BAND_COUNT cascaded
// direct-form-I biquads. Each process word (op 0) carries one Q1.23 sample;
// the block picks its channel from a rotating counter that wraps at the
// channel count register (zero means one, values above MAX_CHANNELS clamp),
// runs it through every band and returns one saturated Q1.23 word together
// with the channel number. Load words (op 1) write one Q4.28 coefficient
// (b0, b1, b2, a1, a2, already normalised by a0) for one band; clear words
// (op 2) zero all filter history and the channel counter; neither gives a
// result. A process word occupies the block while one shared 32x32 multiplier
// forms the five products of each band in turn and a finishing step rounds,
// saturates and writes the band history back. The result sits in an output
// register, so the next word is taken while it waits; only when the following
// result is ready with the previous one still untaken does the block hold.
// Coefficients and history reset to zero through per-entry valid bits, so
// there is no clearing pass after reset. The channel count register is
// written over the cfg port, which is always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.

module cascaded_biquad_equalizer_core #(
  parameter int BAND_COUNT     = cbeq_pkg::DEF_BAND_COUNT,
  parameter int MAX_CHANNELS   = cbeq_pkg::DEF_MAX_CHANNELS,
  parameter int COEF_FRAC_BITS = cbeq_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cbeq_pkg::in_word_t            in_word,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output cbeq_pkg::out_word_t           out_word,
  // channel count register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbeq_pkg::CFG_BITS-1:0] cfg_data
);
  import cbeq_pkg::*;

  cmd_t    cmd;
  status_t status;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencer: band loop, tap counter and result hand-over
  cbeq_ctrl #(
    .BAND_COUNT (BAND_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // stores, multiplier, accumulator and output register
  cbeq_datapath #(
    .BAND_COUNT     (BAND_COUNT),
    .MAX_CHANNELS   (MAX_CHANNELS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
